// ===== sv/semaphore_wait_queue_table_assert.svh =====
// ----------------------------------------------------------------------------
// Semaphore wait queue table assertion macros
// Shared macros for the concurrent checks of the wait queue table.
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_ASSERT_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SWQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/swq_pkg.sv =====
// ----------------------------------------------------------------------------
// Semaphore wait queue table package
// Sizes, memory word layouts, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swq_pkg;

  localparam int SEM_SLOTS  = 32;
  localparam int PROC_SLOTS = 32;

  localparam int SEM_IDX_W  = $clog2(SEM_SLOTS);
  localparam int PROC_IDX_W = $clog2(PROC_SLOTS);
  localparam int MAX_SLOTS  = (SEM_SLOTS > PROC_SLOTS) ? SEM_SLOTS : PROC_SLOTS;
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

  localparam int KEY_W    = 32;
  localparam int PID_W    = 31;
  localparam int HANDLE_W = 5;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
  localparam logic [OP_W-1:0] OP_OUT_PID    = 3'd2;
  localparam logic [OP_W-1:0] OP_OUT_HANDLE = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED  = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [PROC_IDX_W-1:0] head;
    logic [PROC_IDX_W-1:0] tail;
  } desc_word_t;

  typedef struct packed {
    logic [PROC_IDX_W-1:0] next;
    logic                  last;
  } link_word_t;

  typedef struct packed {
    logic [SEM_IDX_W-1:0] desc;
    logic [PID_W-1:0]     pid;
  } info_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_KREQ,
    S_KCHK,
    S_HRD,
    S_HCHK,
    S_PSCAN,
    S_PCHK,
    S_URD,
    S_UCHK,
    S_WRD,
    S_WCHK,
    S_INSA,
    S_INSB,
    S_RESP
  } swq_state_e;

endpackage

// ===== sv/semaphore_wait_queue_table.sv =====
// ----------------------------------------------------------------------------
// Semaphore wait queue table
// Pool of semaphore descriptors, each with a FIFO of blocked process handles.
// ----------------------------------------------------------------------------
// One word in gives one word out. Descriptors (key, head, tail) live in one
// RAM, the per-process links (next, last) in a second and the per-process
// info (descriptor, pid) in a third; active and blocked flags are flip-flops.
// Operations run one at a time on a sequencer. Insert, remove head and peek
// sweep the descriptor RAM for the key, comparing only active descriptors and
// skipping free ones. Out by pid sweeps the info RAM over the blocked entries
// of the PROC_SLOTS process slots. Unlinking a process that is not at the
// head of its queue walks the link RAM from the head. Insert, out by handle
// and unknown codes can be rejected at dispatch. A new word is taken only
// while the sequencer idles; a finished result waits in the output register
// without holding the input.
`timescale 1ns / 1ps

`include "semaphore_wait_queue_table_assert.svh"

module semaphore_wait_queue_table
  import swq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [KEY_W-1:0]    sem_key_i,
  input  logic [HANDLE_W-1:0] proc_handle_i,
  input  logic [PID_W-1:0]    proc_pid_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] found_handle_o,
  output logic [PID_W-1:0]    found_pid_o
);

  swq_state_e state_q, state_d;

  logic [SEM_SLOTS-1:0]  desc_active_q, desc_active_d;
  logic [PROC_SLOTS-1:0] proc_blocked_q, proc_blocked_d;
  logic                  out_valid_q, out_valid_d;

  // Latched request and working registers.
  logic [OP_W-1:0]       op_q, op_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [HANDLE_W-1:0]   h_q, h_d;
  logic [PID_W-1:0]      pid_q, pid_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [SEM_IDX_W-1:0]  free_q, free_d;
  logic                  free_vld_q, free_vld_d;
  logic [SEM_IDX_W-1:0]  d_q, d_d;
  logic [PROC_IDX_W-1:0] cur_q, cur_d;
  logic [PROC_IDX_W-1:0] prev_q, prev_d;
  logic                  new_q, new_d;
  desc_word_t            dw_q, dw_d;
  link_word_t            hl_q, hl_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic [HANDLE_W-1:0]   res_fh_q, res_fh_d;
  logic [PID_W-1:0]      res_fp_q, res_fp_d;
  logic [STATUS_W-1:0]   o_st_q, o_st_d;
  logic [HANDLE_W-1:0]   o_fh_q, o_fh_d;
  logic [PID_W-1:0]      o_fp_q, o_fp_d;

  // RAM ports.
  logic                  desc_we, link_we, info_we;
  logic [SEM_IDX_W-1:0]  desc_waddr, desc_raddr;
  logic [PROC_IDX_W-1:0] link_waddr, link_raddr, info_waddr, info_raddr;
  desc_word_t            desc_wdata, desc_rdata;
  link_word_t            link_wdata, link_rdata;
  info_word_t            info_wdata, info_rdata;

  logic in_acc, out_acc, out_free;
  logic h_ok;
  logic [PROC_IDX_W-1:0] h_idx;
  logic [SEM_IDX_W-1:0]  sidx;
  logic [PROC_IDX_W-1:0] pidx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  // The handle names a slot inside the process pool.
  assign h_ok       = (32'(h_q) < 32'(PROC_SLOTS));
  assign h_idx      = h_q[PROC_IDX_W-1:0];
  assign sidx       = idx_q[SEM_IDX_W-1:0];
  assign pidx       = idx_q[PROC_IDX_W-1:0];

  swq_ram #(.WIDTH($bits(desc_word_t)), .DEPTH(SEM_SLOTS)) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (desc_we),
    .waddr_i(desc_waddr),
    .wdata_i(desc_wdata),
    .raddr_i(desc_raddr),
    .rdata_o(desc_rdata)
  );

  swq_ram #(.WIDTH($bits(link_word_t)), .DEPTH(PROC_SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  swq_ram #(.WIDTH($bits(info_word_t)), .DEPTH(PROC_SLOTS)) u_info_ram (
    .clk_i  (clk_i),
    .we_i   (info_we),
    .waddr_i(info_waddr),
    .wdata_i(info_wdata),
    .raddr_i(info_raddr),
    .rdata_o(info_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DISP;
      end
      S_DISP: begin
        case (op_q)
          OP_INSERT: begin
            if (!h_ok || proc_blocked_q[h_idx]) state_d = S_RESP;
            else state_d = S_KREQ;
          end
          OP_REMOVE, OP_PEEK: state_d = S_KREQ;
          OP_OUT_PID: state_d = S_PSCAN;
          OP_OUT_HANDLE: begin
            if (h_ok && proc_blocked_q[h_idx]) state_d = S_HRD;
            else state_d = S_RESP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_KREQ: begin
        if (idx_q == CNT_W'(SEM_SLOTS)) begin
          if ((op_q == OP_INSERT) && free_vld_q) state_d = S_INSB;
          else state_d = S_RESP;
        end else if (desc_active_q[sidx]) begin
          state_d = S_KCHK;
        end
      end
      S_KCHK: begin
        if (desc_rdata.key == key_q) begin
          state_d = (op_q == OP_INSERT) ? S_INSA : S_HRD;
        end else begin
          state_d = S_KREQ;
        end
      end
      S_HRD:  state_d = S_HCHK;
      S_HCHK: state_d = (op_q == OP_PEEK) ? S_RESP : S_URD;
      S_PSCAN: begin
        if (idx_q == CNT_W'(PROC_SLOTS)) state_d = S_RESP;
        else if (proc_blocked_q[pidx]) state_d = S_PCHK;
      end
      S_PCHK: state_d = (info_rdata.pid == pid_q) ? S_URD : S_PSCAN;
      S_URD:  state_d = S_UCHK;
      S_UCHK: state_d = (desc_rdata.head == cur_q) ? S_RESP : S_WRD;
      S_WRD:  state_d = S_WCHK;
      S_WCHK: begin
        if (link_rdata.last || (link_rdata.next == cur_q)) state_d = S_RESP;
        else state_d = S_WRD;
      end
      S_INSA: state_d = S_INSB;
      S_INSB: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    desc_active_d  = desc_active_q;
    proc_blocked_d = proc_blocked_q;
    out_valid_d    = out_valid_q && !out_acc;
    op_d     = op_q;
    key_d    = key_q;
    h_d      = h_q;
    pid_d    = pid_q;
    idx_d    = idx_q;
    free_d   = free_q;
    free_vld_d = free_vld_q;
    d_d      = d_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    new_d    = new_q;
    dw_d     = dw_q;
    hl_d     = hl_q;
    res_st_d = res_st_q;
    res_fh_d = res_fh_q;
    res_fp_d = res_fp_q;
    o_st_d   = o_st_q;
    o_fh_d   = o_fh_q;
    o_fp_d   = o_fp_q;
    desc_we    = 1'b0;
    desc_waddr = d_q;
    desc_wdata = dw_q;
    desc_raddr = sidx;
    link_we    = 1'b0;
    link_waddr = prev_q;
    link_wdata = '0;
    link_raddr = cur_q;
    info_we    = 1'b0;
    info_waddr = h_idx;
    info_wdata = '0;
    info_raddr = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = op_i;
          key_d      = sem_key_i;
          h_d        = proc_handle_i;
          pid_d      = proc_pid_i;
          idx_d      = '0;
          free_vld_d = 1'b0;
          new_d      = 1'b0;
          res_st_d   = ST_NOT_FOUND;
          res_fh_d   = '0;
          res_fp_d   = '0;
        end
      end
      S_DISP: begin
        if ((op_q == OP_INSERT) && h_ok && proc_blocked_q[h_idx]) begin
          res_st_d = ST_BLOCKED;
        end
        cur_d = h_idx;
      end
      S_KREQ: begin
        if (idx_q == CNT_W'(SEM_SLOTS)) begin
          if (op_q == OP_INSERT) begin
            if (free_vld_q) begin
              d_d   = free_q;
              new_d = 1'b1;
            end else begin
              res_st_d = ST_NO_FREE;
            end
          end
        end else if (!desc_active_q[sidx]) begin
          if (!free_vld_q) begin
            free_d     = sidx;
            free_vld_d = 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      S_KCHK: begin
        if (desc_rdata.key == key_q) begin
          d_d   = sidx;
          dw_d  = desc_rdata;
          cur_d = desc_rdata.head;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_HRD: info_raddr = cur_q;
      S_HCHK: begin
        res_st_d = ST_OK;
        res_fh_d = HANDLE_W'(cur_q);
        res_fp_d = info_rdata.pid;
        d_d      = info_rdata.desc;
      end
      S_PSCAN: begin
        info_raddr = pidx;
        if ((idx_q != CNT_W'(PROC_SLOTS)) && !proc_blocked_q[pidx]) idx_d = idx_q + 1'b1;
      end
      S_PCHK: begin
        if (info_rdata.pid == pid_q) begin
          cur_d    = pidx;
          res_st_d = ST_OK;
          res_fh_d = HANDLE_W'(pidx);
          res_fp_d = info_rdata.pid;
          d_d      = info_rdata.desc;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_URD: begin
        desc_raddr = d_q;
        link_raddr = cur_q;
      end
      S_UCHK: begin
        dw_d   = desc_rdata;
        hl_d   = link_rdata;
        prev_d = desc_rdata.head;
        if (desc_rdata.head == cur_q) begin
          // Unlinking the head: free the descriptor or advance its head.
          if (link_rdata.last) begin
            desc_active_d[d_q] = 1'b0;
          end else begin
            desc_we         = 1'b1;
            desc_wdata      = desc_rdata;
            desc_wdata.head = link_rdata.next;
          end
          proc_blocked_d[cur_q] = 1'b0;
        end
      end
      S_WRD: link_raddr = prev_q;
      S_WCHK: begin
        if (link_rdata.last) begin
          proc_blocked_d[cur_q] = 1'b0;
        end else if (link_rdata.next == cur_q) begin
          link_we = 1'b1;
          if (hl_q.last) begin
            link_wdata.next = cur_q;
            link_wdata.last = 1'b1;
            desc_we         = 1'b1;
            desc_wdata      = dw_q;
            desc_wdata.tail = prev_q;
          end else begin
            link_wdata = hl_q;
          end
          proc_blocked_d[cur_q] = 1'b0;
        end else begin
          prev_d = link_rdata.next;
        end
      end
      S_INSA: begin
        link_we         = 1'b1;
        link_waddr      = dw_q.tail;
        link_wdata.next = h_idx;
        link_wdata.last = 1'b0;
        desc_we         = 1'b1;
        desc_wdata      = dw_q;
        desc_wdata.tail = h_idx;
      end
      S_INSB: begin
        if (new_q) begin
          desc_we            = 1'b1;
          desc_wdata.key     = key_q;
          desc_wdata.head    = h_idx;
          desc_wdata.tail    = h_idx;
          desc_active_d[d_q] = 1'b1;
        end
        link_we         = 1'b1;
        link_waddr      = h_idx;
        link_wdata.next = '0;
        link_wdata.last = 1'b1;
        info_we         = 1'b1;
        info_waddr      = h_idx;
        info_wdata.desc = d_q;
        info_wdata.pid  = pid_q;
        proc_blocked_d[h_idx] = 1'b1;
        res_st_d        = ST_OK;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_st_d      = res_st_q;
          o_fh_d      = res_fh_q;
          o_fp_d      = res_fp_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      desc_active_q  <= '0;
      proc_blocked_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      desc_active_q  <= desc_active_d;
      proc_blocked_q <= proc_blocked_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    h_q        <= h_d;
    pid_q      <= pid_d;
    idx_q      <= idx_d;
    free_q     <= free_d;
    free_vld_q <= free_vld_d;
    d_q        <= d_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    new_q      <= new_d;
    dw_q       <= dw_d;
    hl_q       <= hl_d;
    res_st_q   <= res_st_d;
    res_fh_q   <= res_fh_d;
    res_fp_q   <= res_fp_d;
    o_st_q     <= o_st_d;
    o_fh_q     <= o_fh_d;
    o_fp_q     <= o_fp_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_st_q;
  assign found_handle_o = o_fh_q;
  assign found_pid_o    = o_fp_q;

  // An accepted word always starts with dispatch.
  `SWQ_ASSERT_NEXT(a_accept_disp, in_acc, state_q == S_DISP, "accept did not dispatch")
  // Only active descriptors are compared against the key.
  `SWQ_ASSERT_NOW(a_kchk_active, state_q == S_KCHK, desc_active_q[sidx], "inactive key compare")
  // A result leaving the sequencer shows up on the output and frees the input.
  `SWQ_ASSERT_NEXT(a_resp_out, (state_q == S_RESP) && out_free, out_valid_o && (state_q == S_IDLE), "result not delivered")

endmodule

// ===== sv/swq_ram.sv =====
// ----------------------------------------------------------------------------
// Semaphore wait queue table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
